@@ rtl/core/rrts_pkg.sv @@
// Package for the round-robin tick scheduler.
// Holds register map, widths and parameter defaults; no dependencies.
package rrts_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;
  localparam int LEN_BITS_DEF    = 5;

  localparam int QUANTUM_W = 8;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(6);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_QUANTUM = '0;

endpackage

@@ rtl/core/round_robin_tick_scheduler.sv @@
// An accepted tick item's result item is registered and shown in the next cycle.
// Throughput: one item per cycle while the result side does not stall; the
// whole queue update (retire or rotate, run, admit) is one register pass.
// Reset (synchronous, rst_n low): queue empty, head slice and id counter
// cleared, quantum back to its default. Queue slots are not cleared.
// Round-robin time-slice scheduler top level; uses rrts_pkg.
module round_robin_tick_scheduler
  import rrts_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int LEN_BITS    = LEN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_arrival_valid,
  input  logic [LEN_BITS-1:0]   in_arrival_length,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_ran_valid,
  output logic [ID_BITS-1:0]    out_ran_id,
  output logic [LEN_BITS-1:0]   out_ran_left,
  output logic                  out_created_valid,
  output logic [ID_BITS-1:0]    out_created_id,
  output logic                  out_arrival_dropped
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic [ID_BITS-1:0]   q_id_r    [QUEUE_DEPTH];
  logic [ID_BITS-1:0]   q_id_nxt  [QUEUE_DEPTH];
  logic [LEN_BITS-1:0]  q_left_r  [QUEUE_DEPTH];
  logic [LEN_BITS-1:0]  q_left_nxt[QUEUE_DEPTH];
  logic [ID_BITS-1:0]   mid_id    [QUEUE_DEPTH];
  logic [LEN_BITS-1:0]  mid_left  [QUEUE_DEPTH];

  logic [CNT_W-1:0]     count_r, count_nxt, cnt_a;
  logic [QUANTUM_W-1:0] slice_r, slice_nxt, slice_a;
  logic [ID_BITS-1:0]   id_ctr_r, id_ctr_nxt;
  logic [QUANTUM_W-1:0] quantum_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 ran_valid_r;
  logic [ID_BITS-1:0]   ran_id_r;
  logic [LEN_BITS-1:0]  ran_left_r;
  logic                 created_valid_r;
  logic [ID_BITS-1:0]   created_id_r;
  logic                 dropped_r;

  logic                 take, rot, keep, run, push, drop;
  logic [IDX_W-1:0]     rot_pos, push_pos;
  logic [LEN_BITS-1:0]  run_left;
  logic [ID_BITS-1:0]   new_id;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_QUANTUM);
  assign prdata  = (reg_idx == REG_QUANTUM) ?
                   {{(CFG_DATA_W-QUANTUM_W){1'b0}}, quantum_r} : '0;

  assign in_stall      = out_valid_r && out_stall;
  assign take          = in_valid && !in_stall;
  assign out_valid_nxt = take || (out_valid_r && out_stall);

  always_comb begin
    rot     = (count_r != '0) && ((slice_r >= quantum_r) || (q_left_r[0] == '0));
    keep    = rot && (q_left_r[0] != '0);
    cnt_a   = (rot && !keep) ? count_r - CNT_W'(1) : count_r;
    rot_pos = IDX_W'(count_r - CNT_W'(1));

    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      mid_id[i]   = rot ? q_id_r[i+1]   : q_id_r[i];
      mid_left[i] = rot ? q_left_r[i+1] : q_left_r[i];
    end
    mid_id[QUEUE_DEPTH-1]   = q_id_r[QUEUE_DEPTH-1];
    mid_left[QUEUE_DEPTH-1] = q_left_r[QUEUE_DEPTH-1];
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (keep && (IDX_W'(i) == rot_pos)) begin
        mid_id[i]   = q_id_r[0];
        mid_left[i] = q_left_r[0];
      end
    end

    run      = (cnt_a != '0);
    run_left = (mid_left[0] == '0) ? '0 : mid_left[0] - LEN_BITS'(1);
    slice_a  = rot ? '0 : slice_r;
    slice_nxt = run ? slice_a + QUANTUM_W'(1) : slice_a;

    push     = in_arrival_valid && (cnt_a < CNT_W'(QUEUE_DEPTH));
    drop     = in_arrival_valid && !push;
    new_id   = id_ctr_r + ID_BITS'(1);
    push_pos = cnt_a[IDX_W-1:0];
    id_ctr_nxt = push ? new_id : id_ctr_r;

    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_id_nxt[i]   = mid_id[i];
      q_left_nxt[i] = mid_left[i];
      if (run && (i == 0)) begin
        q_left_nxt[i] = run_left;
      end
      if (push && (IDX_W'(i) == push_pos)) begin
        q_id_nxt[i]   = new_id;
        q_left_nxt[i] = in_arrival_length;
      end
    end

    count_nxt = cnt_a + CNT_W'(push);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      slice_r     <= '0;
      id_ctr_r    <= '0;
      quantum_r   <= QUANTUM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        quantum_r <= pwdata[QUANTUM_W-1:0];
      end
      if (take) begin
        count_r  <= count_nxt;
        slice_r  <= slice_nxt;
        id_ctr_r <= id_ctr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_id_r          <= q_id_nxt;
      q_left_r        <= q_left_nxt;
      ran_valid_r     <= run;
      ran_id_r        <= run ? mid_id[0] : '0;
      ran_left_r      <= run ? run_left : '0;
      created_valid_r <= push;
      created_id_r    <= push ? new_id : '0;
      dropped_r       <= drop;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ran_valid       = ran_valid_r;
  assign out_ran_id          = ran_id_r;
  assign out_ran_left        = ran_left_r;
  assign out_created_valid   = created_valid_r;
  assign out_created_id      = created_id_r;
  assign out_arrival_dropped = dropped_r;

endmodule

@@ rtl/core/rrts_chk.sv @@
// Port-level checker for the round-robin tick scheduler, bound to the top.
// Uses rrts_pkg for parameter defaults and port widths.
module rrts_chk
  import rrts_pkg::*;
#(
  parameter int ID_BITS  = ID_BITS_DEF,
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                in_arrival_valid,
  input logic                out_valid,
  input logic                out_stall,
  input logic                out_ran_valid,
  input logic [ID_BITS-1:0]  out_ran_id,
  input logic [LEN_BITS-1:0] out_ran_left,
  input logic                out_created_valid,
  input logic                out_arrival_dropped
);

  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item produced no result");

  a_arrival_resolved: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_arrival_valid) |=>
      (out_created_valid != out_arrival_dropped))
    else $error("arrival neither admitted nor dropped exactly once");

  a_idle_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ran_valid) |-> (out_ran_id == '0 && out_ran_left == '0))
    else $error("run fields set without a running job");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_ran_id)))
    else $error("stalled result changed");

endmodule

bind round_robin_tick_scheduler rrts_chk #(
  .ID_BITS (ID_BITS),
  .LEN_BITS(LEN_BITS)
) u_rrts_chk (.*);

@@ tb/tb_round_robin_tick_scheduler.sv @@
`timescale 1ns / 100ps
// Testbench for round_robin_tick_scheduler: directed and random tick streams,
// each result item checked against a built-in round-robin queue predictor.
// Depends on rrts_pkg and round_robin_tick_scheduler.
module tb_round_robin_tick_scheduler;
  import rrts_pkg::*;

  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam int ID_W = ID_BITS_DEF;
  localparam int LEN_W = LEN_BITS_DEF;
  localparam int HOLD_CYCLES = 64;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 290;
  localparam int CYCLE_LIMIT = 600000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic             ran_valid;
    logic [ID_W-1:0]  ran_id;
    logic [LEN_W-1:0] ran_left;
    logic             created_valid;
    logic [ID_W-1:0]  created_id;
    logic             arrival_dropped;
  } tick_result_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_arrival_valid = 1'b0;
  logic [LEN_W-1:0]      in_arrival_length = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_ran_valid;
  logic [ID_W-1:0]       out_ran_id;
  logic [LEN_W-1:0]      out_ran_left;
  logic                  out_created_valid;
  logic [ID_W-1:0]       out_created_id;
  logic                  out_arrival_dropped;

  round_robin_tick_scheduler uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_arrival_valid    (in_arrival_valid),
    .in_arrival_length   (in_arrival_length),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ran_valid       (out_ran_valid),
    .out_ran_id          (out_ran_id),
    .out_ran_left        (out_ran_left),
    .out_created_valid   (out_created_valid),
    .out_created_id      (out_created_id),
    .out_arrival_dropped (out_arrival_dropped)
  );

  logic [ID_W-1:0]      sched_ids [QDEPTH];
  logic [LEN_W-1:0]     sched_left [QDEPTH];
  int unsigned          sched_head;
  int unsigned          sched_count;
  logic [QUANTUM_W-1:0] sched_slice;
  logic [QUANTUM_W-1:0] sched_quantum;
  logic [ID_W-1:0]      sched_last_id;

  tick_result_t expected_ticks[$];
  tick_result_t seen_result;
  tick_result_t want_result;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int error_count = 0;
  int tick_count = 0;
  int created_count = 0;
  int dropped_count = 0;
  int empty_count = 0;
  int stalled_cycles = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_scheduler_model();
    sched_head = 0;
    sched_count = 0;
    sched_slice = '0;
    sched_quantum = QUANTUM_RESET;
    sched_last_id = '0;
  endfunction

  function automatic tick_result_t schedule_tick(input logic arrive,
                                                 input logic [LEN_W-1:0] len);
    tick_result_t r;
    logic [ID_W-1:0] rot_id;
    logic [LEN_W-1:0] rot_left;
    int unsigned tail;
    r = '0;
    if (sched_count > 0 &&
        (sched_slice >= sched_quantum || sched_left[sched_head] == '0)) begin
      rot_id = sched_ids[sched_head];
      rot_left = sched_left[sched_head];
      sched_slice = '0;
      sched_head = (sched_head + 1) % QDEPTH;
      sched_count--;
      if (rot_left != '0) begin
        tail = (sched_head + sched_count) % QDEPTH;
        sched_ids[tail] = rot_id;
        sched_left[tail] = rot_left;
        sched_count++;
      end
    end
    if (sched_count > 0) begin
      sched_slice = sched_slice + 1'b1;
      if (sched_left[sched_head] != '0) begin
        sched_left[sched_head] = sched_left[sched_head] - 1'b1;
      end
      r.ran_valid = 1'b1;
      r.ran_id = sched_ids[sched_head];
      r.ran_left = sched_left[sched_head];
    end
    if (arrive) begin
      if (sched_count < QDEPTH) begin
        tail = (sched_head + sched_count) % QDEPTH;
        sched_last_id = sched_last_id + 1'b1;
        sched_ids[tail] = sched_last_id;
        sched_left[tail] = len;
        sched_count++;
        r.created_valid = 1'b1;
        r.created_id = sched_last_id;
      end else begin
        r.arrival_dropped = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] random_length();
    case ($urandom_range(15))
      0: return '0;
      1, 2, 3, 4, 5: return LEN_W'($urandom_range(3, 1));
      default: return LEN_W'($urandom_range((1 << LEN_W) - 1, 1));
    endcase
  endfunction

  task automatic offer_tick(input logic arrive, input logic [LEN_W-1:0] len);
    tick_result_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_arrival_valid <= 1'($urandom);
      in_arrival_length <= LEN_W'($urandom);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_arrival_valid <= arrive;
    in_arrival_length <= len;
    do @(posedge clk); while (in_stall);
    r = schedule_tick(arrive, len);
    expected_ticks.push_back(r);
    tick_count++;
    if (r.created_valid) created_count++;
    if (r.arrival_dropped) dropped_count++;
    if (!r.ran_valid) empty_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [QUANTUM_W-1:0] value);
    wait_drained();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({REG_QUANTUM, 2'b00});
    pwdata <= CFG_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sched_quantum = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_reset_default_quantum();
    offer_tick(1'b0, '1);
    offer_tick(1'b1, '1);
    offer_tick(1'b1, '0);
    repeat (8) offer_tick(1'b0, random_length());
  endtask

  task automatic test_queue_full();
    write_quantum(8'd255);
    repeat (QDEPTH + 1) offer_tick(1'b1, '1);
  endtask

  task automatic test_slice_lowered();
    write_quantum(8'd3);
    repeat (3) offer_tick(1'b0, random_length());
    write_quantum(8'd0);
    repeat (3) offer_tick(1'b1, 5'b10101);
  endtask

  task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                   input logic [QUANTUM_W-1:0] quantum);
    int density;
    write_quantum(quantum);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    density = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: density = 10;
          1: density = 50;
          default: density = 95;
        endcase
      end
      offer_tick($urandom_range(99) < density, random_length());
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(0, 0, 8'd1);
    run_traffic_phase(74, 0, 8'd255);
    run_traffic_phase(0, 74, QUANTUM_W'($urandom_range(254, 2)));
    run_traffic_phase(31, 31, QUANTUM_RESET);
  endtask

  task automatic test_output_backpressure();
    write_quantum(8'd4);
    hold_req++;
    repeat (40) offer_tick(1'($urandom), random_length());
    wait_drained();
    repeat (10) offer_tick(1'b1, random_length());
  endtask

  // hold off for a fixed stretch on request, else stall at random
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) stalled_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      seen_result = {out_ran_valid, out_ran_id, out_ran_left, out_created_valid,
                     out_created_id, out_arrival_dropped};
      if (expected_ticks.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("unexpected result item: ran=%0b id=%0d left=%0d created=%0b id=%0d drop=%0b",
                   seen_result.ran_valid, seen_result.ran_id, seen_result.ran_left,
                   seen_result.created_valid, seen_result.created_id,
                   seen_result.arrival_dropped);
        end
      end else begin
        want_result = expected_ticks.pop_front();
        if (seen_result !== want_result) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("mismatch at %0t: exp ran=%0b id=%0d left=%0d created=%0b id=%0d drop=%0b",
                     $realtime, want_result.ran_valid, want_result.ran_id,
                     want_result.ran_left, want_result.created_valid,
                     want_result.created_id, want_result.arrival_dropped);
            $display("                got ran=%0b id=%0d left=%0d created=%0b id=%0d drop=%0b",
                     seen_result.ran_valid, seen_result.ran_id, seen_result.ran_left,
                     seen_result.created_valid, seen_result.created_id,
                     seen_result.arrival_dropped);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_ticks.size());
      $display("tb_round_robin_tick_scheduler failed");
      $finish;
    end
  end

  initial begin
    reset_scheduler_model();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_default_quantum();
    test_queue_full();
    test_slice_lowered();
    test_random_traffic();
    test_output_backpressure();
    wait_drained();
    $display("ran %0d ticks: %0d jobs created, %0d arrivals refused, %0d empty-queue ticks",
             tick_count, created_count, dropped_count, empty_count);
    $display("quantum 0, 1, 3, 4, 6, 255 and random; input stalled %0d cycles; queue filled",
             stalled_cycles);
    if (error_count == 0 && expected_ticks.size() == 0) begin
      $display("tb_round_robin_tick_scheduler passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb_round_robin_tick_scheduler failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/rrts_pkg.sv
rtl/core/round_robin_tick_scheduler.sv
rtl/core/rrts_chk.sv
tb/tb_round_robin_tick_scheduler.sv
